@@ src/wsd_pkg.sv @@
// Package for the WebSocket frame deframer: parse phases, status codes,
// header constants and the result record shared by the deframer modules.
// No dependencies.
package wsd_pkg;

  // Width of the payload length limit and of the payload byte counter
  localparam int unsigned LEN_W = 25;

  // Limit in force after reset: one mebibyte
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1024 * 1024);

  // Header byte of a close frame
  localparam logic [7:0] CLOSE_HEADER = 8'h88;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  // Extended length byte counts; eight bytes wrap to zero in three bits
  localparam logic [2:0] EXT_CNT16   = 3'd2;
  localparam logic [2:0] EXT_CNT64   = 3'd0;
  localparam logic [2:0] MASK_KEY_CNT = 3'd4;

  // Where the parser stands within a frame
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_HALTED  = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_CLOSE    = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  // One result request
  typedef struct packed {
    logic [7:0] payload_byte;
    status_t    status;
    logic       frame_end;
  } result_t;

endpackage

@@ src/wsd_in_reg.sv @@
// Input register of the WebSocket frame deframer: holds one received byte
// until the parser takes it. Depends on nothing.
module wsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // Accept a new request whenever the slot is empty or drains this cycle
  assign in_ready = !held_valid || take;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Capture the byte with its request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

@@ src/wsd_parser.sv @@
// Frame parser of the WebSocket frame deframer: header, length, mask key
// and payload state, unmasking and status generation. Uses wsd_pkg.
module wsd_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               rx_byte,
  input  logic                     cfg_we,
  input  logic [wsd_pkg::LEN_W-1:0] cfg_wdata,
  output logic                     res_valid,
  output wsd_pkg::result_t         res
);

  wsd_pkg::phase_t            parse_phase, parse_phase_next;
  logic                       is_masked, is_masked_next;
  logic                       is_close, is_close_next;
  logic [63:0]                frame_length, frame_length_next;
  logic [2:0]                 ext_byte_count, ext_byte_count_next;
  logic [31:0]                mask_key, mask_key_next;
  logic [wsd_pkg::LEN_W-1:0]  payload_count, payload_count_next;
  logic [wsd_pkg::LEN_W-1:0]  max_payload_len;

  logic                       hdr_done;
  logic [63:0]                hdr_len;
  logic                       len_over;
  logic [6:0]                 len_code;
  logic [7:0]                 key_byte;
  logic                       last_byte;

  assign len_code = rx_byte[6:0];

  // Pick the mask key byte for this payload position, first byte on top
  always_comb begin
    unique case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Payload counter after this byte reaches the frame length: last byte
  assign last_byte = (payload_count + 1'b1) >= frame_length[wsd_pkg::LEN_W-1:0];

  // Length above limit: any high bit set, or low part larger than the limit
  assign len_over = (|hdr_len[63:wsd_pkg::LEN_W]) ||
                    (hdr_len[wsd_pkg::LEN_W-1:0] > max_payload_len);

  // Next state and result for the byte in hand
  always_comb begin
    parse_phase_next    = parse_phase;
    is_masked_next      = is_masked;
    is_close_next       = is_close;
    frame_length_next   = frame_length;
    ext_byte_count_next = ext_byte_count;
    mask_key_next       = mask_key;
    payload_count_next  = payload_count;
    hdr_done            = 1'b0;
    hdr_len             = frame_length;
    res_valid           = 1'b0;
    res                 = '{payload_byte: 8'h00, status: wsd_pkg::ST_PAYLOAD,
                            frame_end: 1'b0};

    unique case (parse_phase)
      wsd_pkg::PH_HEADER: begin
        is_close_next       = (rx_byte == wsd_pkg::CLOSE_HEADER);
        is_masked_next      = 1'b0;
        mask_key_next       = '0;
        frame_length_next   = '0;
        ext_byte_count_next = '0;
        payload_count_next  = '0;
        parse_phase_next    = wsd_pkg::PH_LENGTH;
      end
      wsd_pkg::PH_LENGTH: begin
        is_masked_next = rx_byte[7];
        if (len_code == wsd_pkg::LEN_CODE16 || len_code == wsd_pkg::LEN_CODE64) begin
          frame_length_next   = '0;
          ext_byte_count_next = (len_code == wsd_pkg::LEN_CODE16) ?
                                wsd_pkg::EXT_CNT16 : wsd_pkg::EXT_CNT64;
          parse_phase_next    = wsd_pkg::PH_EXTLEN;
        end else begin
          frame_length_next = {57'd0, len_code};
          if (rx_byte[7]) begin
            ext_byte_count_next = wsd_pkg::MASK_KEY_CNT;
            parse_phase_next    = wsd_pkg::PH_MASK;
          end else begin
            hdr_done = 1'b1;
            hdr_len  = frame_length_next;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        frame_length_next   = {frame_length[55:0], rx_byte};
        ext_byte_count_next = ext_byte_count - 1'b1;
        if (ext_byte_count_next == 3'd0) begin
          if (is_masked) begin
            ext_byte_count_next = wsd_pkg::MASK_KEY_CNT;
            parse_phase_next    = wsd_pkg::PH_MASK;
          end else begin
            hdr_done = 1'b1;
            hdr_len  = frame_length_next;
          end
        end
      end
      wsd_pkg::PH_MASK: begin
        mask_key_next       = {mask_key[23:0], rx_byte};
        ext_byte_count_next = ext_byte_count - 1'b1;
        if (ext_byte_count_next == 3'd0) begin
          hdr_done = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        payload_count_next = payload_count + 1'b1;
        if (last_byte) begin
          parse_phase_next = wsd_pkg::PH_HEADER;
        end
        if (is_close) begin
          if (last_byte) begin
            res_valid = 1'b1;
            res = '{payload_byte: 8'h00, status: wsd_pkg::ST_CLOSE, frame_end: 1'b1};
          end
        end else begin
          res_valid = 1'b1;
          res = '{payload_byte: rx_byte ^ key_byte, status: wsd_pkg::ST_PAYLOAD,
                  frame_end: last_byte};
        end
      end
      default: begin
        parse_phase_next = wsd_pkg::PH_HALTED;
      end
    endcase

    // Header complete: check the length, flag oversize or empty frames
    if (hdr_done) begin
      payload_count_next = '0;
      if (len_over) begin
        parse_phase_next = wsd_pkg::PH_HALTED;
        res_valid        = 1'b1;
        res = '{payload_byte: 8'h00, status: wsd_pkg::ST_OVERSIZE, frame_end: 1'b1};
      end else if (hdr_len == 64'd0) begin
        parse_phase_next = wsd_pkg::PH_HEADER;
        res_valid        = 1'b1;
        res = '{payload_byte: 8'h00,
                status: is_close ? wsd_pkg::ST_CLOSE : wsd_pkg::ST_EMPTY,
                frame_end: 1'b1};
      end else begin
        parse_phase_next = wsd_pkg::PH_PAYLOAD;
      end
    end
  end

  // Advance the parse state on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= wsd_pkg::PH_HEADER;
      is_masked      <= 1'b0;
      is_close       <= 1'b0;
      frame_length   <= '0;
      ext_byte_count <= '0;
      mask_key       <= '0;
      payload_count  <= '0;
    end else if (step) begin
      parse_phase    <= parse_phase_next;
      is_masked      <= is_masked_next;
      is_close       <= is_close_next;
      frame_length   <= frame_length_next;
      ext_byte_count <= ext_byte_count_next;
      mask_key       <= mask_key_next;
      payload_count  <= payload_count_next;
    end
  end

  // Hold the length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= wsd_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_payload_len <= cfg_wdata;
    end
  end

endmodule

@@ src/wsd_out_reg.sv @@
// Result register of the WebSocket frame deframer: holds one result request
// until the sink takes it. Uses wsd_pkg.
module wsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsd_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       payload_byte,
  output logic [1:0]       status,
  output logic             frame_end
);

  wsd_pkg::result_t held;

  // Slot is free when empty or being taken this cycle
  assign free = !out_valid || out_ready;

  // Hold the valid flag: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result fields
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign payload_byte = held.payload_byte;
  assign status       = held.status;
  assign frame_end    = held.frame_end;

endmodule

@@ src/websocket_frame_deframer_unit.sv @@
// Top level of the WebSocket frame deframer: input register, frame parser
// and result register. Uses wsd_pkg, wsd_in_reg, wsd_parser, wsd_out_reg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_ready   | rx_byte[7:0]
//   result   | out_valid / out_ready | payload_byte[7:0], status[1:0],
//            |                       | frame_end
//   config   | cfg_we                | cfg_wdata[24:0] (max_payload_len)
//
// One byte is taken every cycle while no result stalls. After a byte is
// accepted, the input register holds it, the parser works on it in one
// pass and the result register captures the outcome for presentation.
// Reset (rst, synchronous) returns the parser to the header byte and the
// length limit to 1 MiB; no clearing pass follows.
// A stalled result holds the byte in hand, whether or not that byte makes a
// result, and so holds the input as well; with out_ready high nothing stalls.
module websocket_frame_deframer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                payload_byte,
  output logic [1:0]                status,
  output logic                      frame_end,
  input  logic                      cfg_we,
  input  logic [wsd_pkg::LEN_W-1:0] cfg_wdata
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             take;
  logic             out_free;
  logic             res_valid;
  wsd_pkg::result_t res;

  // Advance the byte in hand once there is room for any result it makes
  assign take = held_valid && out_free;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .rx_byte   (held_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (take && res_valid),
    .res          (res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .status       (status),
    .frame_end    (frame_end)
  );

endmodule
